>>> rtl/core/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the beep pattern sequencer.
// ---------------------------------------------------------------------------
package bps_pkg;

   localparam int unsigned TICK_W   = 16;
   localparam int unsigned BEEPS_W  = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_MARK  = 2'd1,
      PH_SPACE = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HALF  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LONG  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_ON  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_OFF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_ON   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_ON   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_OFF  = 3'd5;

   localparam logic [TICK_W-1:0] RST_SHORT_ON  = 16'd50;
   localparam logic [TICK_W-1:0] RST_SHORT_OFF = 16'd100;
   localparam logic [TICK_W-1:0] RST_HALF_ON   = 16'd200;
   localparam logic [TICK_W-1:0] RST_HALF_OFF  = 16'd500;
   localparam logic [TICK_W-1:0] RST_LONG_ON   = 16'd1200;
   localparam logic [TICK_W-1:0] RST_LONG_OFF  = 16'd1500;

   typedef struct packed {
      logic [TICK_W-1:0] on_ticks;
      logic [TICK_W-1:0] off_ticks;
   } reload_type;

endpackage

>>> rtl/core/bps_csr.sv
// ---------------------------------------------------------------------------
// bps_csr
// Duration registers and selection of the on/off pair for a beep kind.
// ---------------------------------------------------------------------------
module bps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [bps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bps_pkg::TICK_W-1:0]         csr_data,
   input  logic [bps_pkg::KIND_W-1:0]         kind,
   output bps_pkg::reload_type                reload
);

   logic [bps_pkg::TICK_W-1:0] short_on_ff, short_off_ff;
   logic [bps_pkg::TICK_W-1:0] half_on_ff, half_off_ff;
   logic [bps_pkg::TICK_W-1:0] long_on_ff, long_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_on_ff  <= bps_pkg::RST_SHORT_ON;
         short_off_ff <= bps_pkg::RST_SHORT_OFF;
         half_on_ff   <= bps_pkg::RST_HALF_ON;
         half_off_ff  <= bps_pkg::RST_HALF_OFF;
         long_on_ff   <= bps_pkg::RST_LONG_ON;
         long_off_ff  <= bps_pkg::RST_LONG_OFF;
      end else if (csr_valid) begin
         unique case (csr_index)
            bps_pkg::CSR_SHORT_ON:  short_on_ff  <= csr_data;
            bps_pkg::CSR_SHORT_OFF: short_off_ff <= csr_data;
            bps_pkg::CSR_HALF_ON:   half_on_ff   <= csr_data;
            bps_pkg::CSR_HALF_OFF:  half_off_ff  <= csr_data;
            bps_pkg::CSR_LONG_ON:   long_on_ff   <= csr_data;
            bps_pkg::CSR_LONG_OFF:  long_off_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // kinds other than half and long (short and stop) select the short pair
   always_comb begin
      unique case (kind)
         bps_pkg::KIND_HALF: begin
            reload.on_ticks  = half_on_ff;
            reload.off_ticks = half_off_ff;
         end
         bps_pkg::KIND_LONG: begin
            reload.on_ticks  = long_on_ff;
            reload.off_ticks = long_off_ff;
         end
         default: begin
            reload.on_ticks  = short_on_ff;
            reload.off_ticks = short_off_ff;
         end
      endcase
   end

endmodule

>>> rtl/core/beep_pattern_sequencer.sv
// ---------------------------------------------------------------------------
// beep_pattern_sequencer
// Buzzer beep sequencer: ticks and commands step a mark/space pattern.
// Response: an accepted req beat's rsp beat is registered, valid in the next cycle.
// Throughput: one beat per cycle while rsp_ready is high; the rsp register
// drains while the next beat is taken, set by the single state-update stage.
// Reset: synchronous; phase idle, counters cleared, durations to defaults.
// ---------------------------------------------------------------------------
module beep_pattern_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [bps_pkg::KIND_W-1:0]       req_beep_kind,
   input  logic [bps_pkg::BEEPS_W-1:0]      req_repeat_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_buzzer_level,
   output logic                             rsp_is_free,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bps_pkg::TICK_W-1:0]       csr_data
);

   bps_pkg::phase_type              phase_ff, phase_in;
   logic [bps_pkg::TICK_W-1:0]      countdown_ff, countdown_in, count_dec;
   logic [bps_pkg::BEEPS_W-1:0]     beeps_ff, beeps_in;
   logic [bps_pkg::TICK_W-1:0]      on_reload_ff, on_reload_in;
   logic [bps_pkg::TICK_W-1:0]      off_reload_ff, off_reload_in;
   logic                            buzzer_ff, buzzer_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_buzzer_ff, rsp_free_ff;
   logic                            req_fire;
   bps_pkg::reload_type             reload;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   bps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .kind      (req_beep_kind),
      .reload    (reload)
   );

   assign count_dec = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;

   always_comb begin
      phase_in      = phase_ff;
      countdown_in  = countdown_ff;
      beeps_in      = beeps_ff;
      on_reload_in  = on_reload_ff;
      off_reload_in = off_reload_ff;
      buzzer_in     = buzzer_ff;
      if (req_opcode == bps_pkg::OP_COMMAND) begin
         if (req_beep_kind == bps_pkg::KIND_STOP) begin
            phase_in = bps_pkg::PH_STOP;
         end else begin
            on_reload_in  = reload.on_ticks;
            off_reload_in = reload.off_ticks;
            phase_in      = bps_pkg::PH_MARK;
            countdown_in  = '0;
            beeps_in      = req_repeat_count;
         end
      end else begin
         countdown_in = count_dec;
         unique case (phase_ff)
            bps_pkg::PH_MARK: begin
               if (count_dec == '0) begin
                  buzzer_in    = 1'b1;
                  phase_in     = bps_pkg::PH_SPACE;
                  countdown_in = on_reload_ff;
               end
            end
            bps_pkg::PH_SPACE: begin
               if (count_dec == '0) begin
                  if (beeps_ff > bps_pkg::BEEPS_W'(1)) begin
                     beeps_in     = beeps_ff - 1'b1;
                     buzzer_in    = 1'b0;
                     phase_in     = bps_pkg::PH_MARK;
                     countdown_in = off_reload_ff;
                  end else begin
                     phase_in = bps_pkg::PH_STOP;
                  end
               end
            end
            bps_pkg::PH_STOP: begin
               buzzer_in = 1'b0;
               phase_in  = bps_pkg::PH_IDLE;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bps_pkg::PH_IDLE;
         countdown_ff  <= '0;
         beeps_ff      <= '0;
         on_reload_ff  <= '0;
         off_reload_ff <= '0;
         buzzer_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff      <= phase_in;
            countdown_ff  <= countdown_in;
            beeps_ff      <= beeps_in;
            on_reload_ff  <= on_reload_in;
            off_reload_ff <= off_reload_in;
            buzzer_ff     <= buzzer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_buzzer_ff <= buzzer_in;
         rsp_free_ff   <= (phase_in == bps_pkg::PH_IDLE);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_buzzer_level = rsp_buzzer_ff;
   assign rsp_is_free      = rsp_free_ff;

   a_free_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_free_ff == (phase_ff == bps_pkg::PH_IDLE)))
      else $error("is_free disagrees with phase");

   a_level_tracks_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_buzzer_ff == buzzer_ff))
      else $error("buzzer level disagrees with drive");

   a_stop_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == bps_pkg::OP_TICK && phase_ff == bps_pkg::PH_STOP)
      |=> (phase_ff == bps_pkg::PH_IDLE && !buzzer_ff))
      else $error("stop phase did not return to idle");

   a_command_starts_mark: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == bps_pkg::OP_COMMAND
       && req_beep_kind != bps_pkg::KIND_STOP)
      |=> (phase_ff == bps_pkg::PH_MARK && countdown_ff == '0))
      else $error("command did not start mark phase");

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for beep_pattern_sequencer. A table of directed beats covers
// stop, short, half and long commands, restarts and ticks while idle, then
// random command-and-tick sequences run under several duration settings.
// Every rsp beat is compared against a cycle-free sequencer model kept in
// step with the accepted req beats, or for typed rows against the table;
// the sender idles in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [bps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;
   localparam int unsigned PHASE_BEATS = 286;
   localparam int unsigned DIR_ROWS = 25;

   typedef enum int unsigned {
      DUR_ZERO,
      DUR_TINY,
      DUR_MAX,
      DUR_SMALL,
      DUR_MIXED
   } dur_profile_type;

   typedef struct packed {
      logic buzz;
      logic free;
   } buzzer_view_type;

   typedef struct packed {
      logic                        op;
      logic [bps_pkg::KIND_W-1:0]  kind;
      logic [bps_pkg::BEEPS_W-1:0] reps;
      logic                        typed;
      logic                        buzz;
      logic                        free;
   } beep_row_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = bps_pkg::OP_TICK;
   logic [bps_pkg::KIND_W-1:0]    req_beep_kind = bps_pkg::KIND_STOP;
   logic [bps_pkg::BEEPS_W-1:0]   req_repeat_count = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_buzzer_level;
   logic                          rsp_is_free;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bps_pkg::CSR_IDX_W-1:0] csr_index = bps_pkg::CSR_SHORT_ON;
   logic [bps_pkg::TICK_W-1:0]    csr_data = '0;

   logic row_typed = PRED;
   logic row_buzz = 1'b0;
   logic row_free = 1'b0;

   bps_pkg::phase_type          seq_phase = bps_pkg::PH_IDLE;
   logic [bps_pkg::TICK_W-1:0]  seq_count = '0;
   logic [bps_pkg::BEEPS_W-1:0] seq_beeps = '0;
   logic [bps_pkg::TICK_W-1:0]  seq_on = '0;
   logic [bps_pkg::TICK_W-1:0]  seq_off = '0;
   logic                        seq_buzz = 1'b0;
   logic [bps_pkg::TICK_W-1:0]  dur_copy [0:5] = '{
      bps_pkg::RST_SHORT_ON, bps_pkg::RST_SHORT_OFF, bps_pkg::RST_HALF_ON,
      bps_pkg::RST_HALF_OFF, bps_pkg::RST_LONG_ON, bps_pkg::RST_LONG_OFF};

   buzzer_view_type due_levels [$];
   int unsigned     mismatches = 0;
   int unsigned     burst_left = 0;

   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   beep_row_type dir_rows [DIR_ROWS] = '{
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b1},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP,  8'd255, TYPED, 1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_LONG,  8'd255, TYPED, 1'b0, 1'b1},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_SHORT, 8'd0,   TYPED, 1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_LONG,  8'd255, PRED,  1'b0, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b1},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_LONG,  8'd255, TYPED, 1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_HALF,  8'd1,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_HALF,  8'd170, TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_SHORT, 8'd2,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_SHORT, 8'd85,  PRED,  1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   PRED,  1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_LONG,  8'd255, PRED,  1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_HALF,  8'd1,   PRED,  1'b0, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP,  8'd128, TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b1},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b1},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_LONG,  8'd1,   TYPED, 1'b0, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b1, 1'b0},
      '{bps_pkg::OP_TICK,    bps_pkg::KIND_STOP,  8'd0,   TYPED, 1'b0, 1'b1}
   };

   beep_pattern_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_beep_kind    (req_beep_kind),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_buzzer_level (rsp_buzzer_level),
      .rsp_is_free      (rsp_is_free),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic buzzer_view_type next_buzzer_view(
      input logic                        op,
      input logic [bps_pkg::KIND_W-1:0]  kind,
      input logic [bps_pkg::BEEPS_W-1:0] reps);
      buzzer_view_type view;
      if (op == bps_pkg::OP_COMMAND) begin
         if (kind == bps_pkg::KIND_STOP) begin
            seq_phase = bps_pkg::PH_STOP;
         end else begin
            case (kind)
               bps_pkg::KIND_LONG: begin
                  seq_on  = dur_copy[bps_pkg::CSR_LONG_ON];
                  seq_off = dur_copy[bps_pkg::CSR_LONG_OFF];
               end
               bps_pkg::KIND_HALF: begin
                  seq_on  = dur_copy[bps_pkg::CSR_HALF_ON];
                  seq_off = dur_copy[bps_pkg::CSR_HALF_OFF];
               end
               default: begin
                  seq_on  = dur_copy[bps_pkg::CSR_SHORT_ON];
                  seq_off = dur_copy[bps_pkg::CSR_SHORT_OFF];
               end
            endcase
            seq_phase = bps_pkg::PH_MARK;
            seq_count = '0;
            seq_beeps = reps;
         end
      end else begin
         if (seq_count != '0)
            seq_count = seq_count - 1'b1;
         case (seq_phase)
            bps_pkg::PH_MARK: begin
               if (seq_count == '0) begin
                  seq_buzz  = 1'b1;
                  seq_phase = bps_pkg::PH_SPACE;
                  seq_count = seq_on;
               end
            end
            bps_pkg::PH_SPACE: begin
               if (seq_count == '0) begin
                  if (seq_beeps > 8'd1) begin
                     seq_beeps = seq_beeps - 1'b1;
                     seq_buzz  = 1'b0;
                     seq_phase = bps_pkg::PH_MARK;
                     seq_count = seq_off;
                  end else begin
                     seq_phase = bps_pkg::PH_STOP;
                  end
               end
            end
            bps_pkg::PH_STOP: begin
               seq_buzz  = 1'b0;
               seq_phase = bps_pkg::PH_IDLE;
            end
            default: ;
         endcase
      end
      view.buzz = seq_buzz;
      view.free = (seq_phase == bps_pkg::PH_IDLE);
      return view;
   endfunction

   always @(posedge clock) begin
      buzzer_view_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = next_buzzer_view(req_opcode, req_beep_kind, req_repeat_count);
            if (row_typed)
               want = {row_buzz, row_free};
            due_levels.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_levels.size() == 0) begin
               mismatches++;
               $display("%0t: rsp beat with nothing due (buzzer %0b, free %0b)",
                        $time, rsp_buzzer_level, rsp_is_free);
            end else begin
               want = due_levels.pop_front();
               if (rsp_buzzer_level !== want.buzz) begin
                  mismatches++;
                  $display("%0t: buzzer_level expected %0b, got %0b",
                           $time, want.buzz, rsp_buzzer_level);
               end
               if (rsp_is_free !== want.free) begin
                  mismatches++;
                  $display("%0t: is_free expected %0b, got %0b",
                           $time, want.free, rsp_is_free);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 80);
      end else begin
         stall_left--;
      end
      stall_phase++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_phase % 3) != 0;
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_beat(input logic op, input logic [bps_pkg::KIND_W-1:0] kind,
                            input logic [bps_pkg::BEEPS_W-1:0] reps, input logic typed,
                            input logic buzz, input logic free);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_beep_kind    <= kind;
      req_repeat_count <= reps;
      row_typed        <= typed;
      row_buzz         <= buzz;
      row_free         <= free;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_levels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bps_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bps_pkg::TICK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= bps_pkg::CSR_LONG_OFF)
         dur_copy[idx] = value;
   endtask

   task automatic program_durations(input dur_profile_type profile);
      logic [bps_pkg::TICK_W-1:0] value;
      int unsigned i;
      for (i = 0; i < 6; i++) begin
         case (profile)
            DUR_ZERO:  value = '0;
            DUR_TINY:  value = 16'($urandom_range(0, 3));
            DUR_MAX:   value = '1;
            DUR_SMALL: value = 16'($urandom_range(0, 6));
            default:   value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 10));
         endcase
         write_reg(bps_pkg::CSR_IDX_W'(i), value);
      end
      if (profile == DUR_SMALL) begin
         write_reg(CSR_UNUSED_LO, 16'($urandom));
         write_reg(CSR_UNUSED_HI, 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_sequences(input int unsigned n_beats);
      int unsigned sent;
      int unsigned run;
      int unsigned k;
      logic [bps_pkg::BEEPS_W-1:0] reps;
      sent = 0;
      while (sent < n_beats) begin
         if ($urandom_range(0, 99) < 80) begin
            reps = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            send_beat(bps_pkg::OP_COMMAND, bps_pkg::KIND_W'($urandom_range(1, 3)), reps,
                      PRED, 1'b0, 1'b0);
            run = $urandom_range(1, 30);
            for (k = 0; k < run; k++) begin
               if ($urandom_range(0, 39) == 0)
                  send_beat(bps_pkg::OP_COMMAND, bps_pkg::KIND_STOP, 8'($urandom),
                            PRED, 1'b0, 1'b0);
               else
                  send_beat(bps_pkg::OP_TICK, bps_pkg::KIND_W'($urandom), 8'($urandom),
                            PRED, 1'b0, 1'b0);
            end
            sent += run + 1;
         end else begin
            send_beat(1'($urandom), bps_pkg::KIND_W'($urandom), 8'($urandom),
                      PRED, 1'b0, 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < DIR_ROWS; r++)
         send_beat(dir_rows[r].op, dir_rows[r].kind, dir_rows[r].reps,
                   dir_rows[r].typed, dir_rows[r].buzz, dir_rows[r].free);
      settle();
      program_durations(DUR_ZERO);
      random_sequences(PHASE_BEATS);
      settle();
      program_durations(DUR_TINY);
      random_sequences(PHASE_BEATS);
      settle();
      program_durations(DUR_MAX);
      random_sequences(PHASE_BEATS);
      settle();
      program_durations(DUR_SMALL);
      random_sequences(PHASE_BEATS);
      settle();
      program_durations(DUR_MIXED);
      random_sequences(PHASE_BEATS);
      settle();
      if (mismatches == 0 && due_levels.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
